@@ rtl/bpr_pkg.sv @@
// Package: shared types, reset values and register indexes for the blue pixel run segmenter.
`timescale 1ns / 1ps

package bpr_pkg;

  // Fixed field widths
  localparam int COL_W    = 10;
  localparam int LINE_W   = 10;
  localparam int PIX_W    = 16;
  localparam int SEGW_W   = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Default segment cap per row
  localparam int BPR_MAX_RUNS = 12;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_BLUE_LEVEL   = 3'd0,
    REG_BRIGHT_FLOOR     = 3'd1,
    REG_RED_LEAD         = 3'd2,
    REG_GRN_LEAD         = 3'd3,
    REG_SCORE_FLOOR      = 3'd4,
    REG_MIN_RUN_WIDTH    = 3'd5,
    REG_MAX_GAP          = 3'd6,
    REG_MAX_RUNS_PER_ROW = 3'd7
  } cfg_reg_t;

  // Register file contents
  typedef struct packed {
    logic [4:0] min_blue_level;
    logic [6:0] bright_floor;
    logic [4:0] red_lead;
    logic [4:0] grn_lead;
    logic [6:0] score_floor;   // two's complement
    logic [9:0] min_run_width;
    logic [3:0] max_gap;
    logic [3:0] max_runs_per_row;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    min_blue_level:   5'd10,
    bright_floor:     7'd18,
    red_lead:         5'd5,
    grn_lead:         5'd4,
    score_floor:      7'd9,
    min_run_width:    10'd4,
    max_gap:          4'd2,
    max_runs_per_row: 4'd12
  };

  // One input beat
  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [COL_W-1:0]  column;
    logic [LINE_W-1:0] line;
    logic              row_end;
  } pix_t;

  // One result beat
  typedef struct packed {
    logic              is_blue;
    logic              segment_valid;
    logic [COL_W-1:0]  segment_first;
    logic [COL_W-1:0]  segment_end;
    logic [COL_W-1:0]  segment_center;
    logic [SEGW_W-1:0] segment_span;
    logic [LINE_W-1:0] segment_row;
  } seg_t;

endpackage

@@ rtl/bpr_if.sv @@
// Interfaces: pixel input channel, segment result channel and register write channel.
`timescale 1ns / 1ps

interface bpr_pix_if;
  import bpr_pkg::*;
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  pixel;
  logic [COL_W-1:0]  column;
  logic [LINE_W-1:0] line;
  logic              row_end;

  modport source (output valid, pixel, column, line, row_end, input ready);
  modport sink   (input valid, pixel, column, line, row_end, output ready);
endinterface

interface bpr_seg_if;
  import bpr_pkg::*;
  logic              valid;
  logic              ready;
  logic              is_blue;
  logic              segment_valid;
  logic [COL_W-1:0]  segment_first;
  logic [COL_W-1:0]  segment_end;
  logic [COL_W-1:0]  segment_center;
  logic [SEGW_W-1:0] segment_span;
  logic [LINE_W-1:0] segment_row;

  modport source (output valid, is_blue, segment_valid, segment_first, segment_end,
                  segment_center, segment_span, segment_row, input ready);
  modport sink   (input valid, is_blue, segment_valid, segment_first, segment_end,
                  segment_center, segment_span, segment_row, output ready);
endinterface

interface bpr_cfg_if;
  import bpr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/bpr_cfg.sv @@
// Register file for the classification and run thresholds.
`timescale 1ns / 1ps

module bpr_cfg
  import bpr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write into the addressed field
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_MIN_BLUE_LEVEL:   cfg_nxt.min_blue_level   = wr_data[4:0];
        REG_BRIGHT_FLOOR:     cfg_nxt.bright_floor     = wr_data[6:0];
        REG_RED_LEAD:         cfg_nxt.red_lead         = wr_data[4:0];
        REG_GRN_LEAD:         cfg_nxt.grn_lead         = wr_data[4:0];
        REG_SCORE_FLOOR:      cfg_nxt.score_floor      = wr_data[6:0];
        REG_MIN_RUN_WIDTH:    cfg_nxt.min_run_width    = wr_data[9:0];
        REG_MAX_GAP:          cfg_nxt.max_gap          = wr_data[3:0];
        REG_MAX_RUNS_PER_ROW: cfg_nxt.max_runs_per_row = wr_data[3:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/bpr_classify.sv @@
// Blue pixel classifier: threshold tests on the RGB565 components.
`timescale 1ns / 1ps

module bpr_classify
  import bpr_pkg::*;
(
  input  logic [PIX_W-1:0] pixel,
  input  cfg_t             cfg,
  output logic             is_blue
);

  logic [4:0]         r5, g5, b5;
  logic [6:0]         bright;
  logic signed [6:0]  red_diff, green_diff;
  logic signed [7:0]  score;
  logic signed [7:0]  score_min;
  logic [12:0]        blue_x100, bright_x45;
  logic               ratio_ok;

  // Split components; green drops its low bit
  assign r5 = pixel[15:11];
  assign g5 = pixel[10:6];
  assign b5 = pixel[4:0];

  assign bright     = 7'(r5) + 7'(g5) + 7'(b5);
  assign red_diff   = $signed({2'b00, b5}) - $signed({2'b00, r5});
  assign green_diff = $signed({2'b00, b5}) - $signed({2'b00, g5});
  assign score      = $signed({2'b00, b5, 1'b0}) - $signed({3'b000, r5})
                    - $signed({3'b000, g5});
  assign score_min  = $signed({cfg.score_floor[6], cfg.score_floor});

  // Blue share of brightness at least 45 percent
  assign blue_x100  = 13'(b5) * 13'd100;
  assign bright_x45 = 13'(bright) * 13'd45;
  assign ratio_ok   = (blue_x100 >= bright_x45);

  // All tests must pass; the score test and the ratio test are alternatives, either suffices
  assign is_blue = (bright >= cfg.bright_floor)
                && (b5 >= cfg.min_blue_level)
                && (red_diff >= $signed({2'b00, cfg.red_lead}))
                && (green_diff >= $signed({2'b00, cfg.grn_lead}))
                && ((score >= score_min) || ratio_ok);

endmodule

@@ rtl/bpr_run.sv @@
// Run tracker: gap-tolerant run state, segment emission and result register.
`timescale 1ns / 1ps

module bpr_run
  import bpr_pkg::*;
#(
  parameter int MAX_RUNS = BPR_MAX_RUNS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic advance,
  input  pix_t item,
  input  logic is_blue,
  input  cfg_t cfg,
  input  logic out_ready,
  output logic out_valid,
  output seg_t result
);

  localparam int RUNS_W = $clog2(MAX_RUNS + 1);
  localparam logic [3:0] RUN_CAP = 4'(MAX_RUNS);

  logic              run_open_r, run_open_nxt;
  logic [COL_W-1:0]  run_start_r, run_start_nxt;
  logic [COL_W-1:0]  last_col_r, last_col_nxt;
  logic [3:0]        gap_r, gap_nxt;
  logic [RUNS_W-1:0] runs_r, runs_nxt;
  logic              out_valid_r, out_valid_nxt;
  seg_t              result_r, result_nxt;

  logic              open_step;
  logic [COL_W-1:0]  start_step, last_step;
  logic              gap_close, row_close, closing;
  logic [COL_W-1:0]  cls_start, cls_end;
  logic [3:0]        limit;
  logic [SEGW_W-1:0] width;
  logic [COL_W:0]    col_sum;
  logic              emit;

  // Blue extends or opens the run
  assign open_step  = is_blue | run_open_r;
  assign start_step = (is_blue && !run_open_r) ? item.column : run_start_r;
  assign last_step  = is_blue ? item.column : last_col_r;

  // Gap overflow closes first; row end closes whatever stays open
  assign gap_close = !is_blue && run_open_r && (gap_r >= cfg.max_gap);
  assign row_close = item.row_end && open_step && !gap_close;
  assign closing   = gap_close | row_close;
  assign cls_start = gap_close ? run_start_r : start_step;
  assign cls_end   = gap_close ? last_col_r  : last_step;

  // Emission check
  assign limit   = (cfg.max_runs_per_row < RUN_CAP) ? cfg.max_runs_per_row : RUN_CAP;
  assign width   = SEGW_W'(cls_end) - SEGW_W'(cls_start) + SEGW_W'(1);
  assign col_sum = (COL_W+1)'(cls_start) + (COL_W+1)'(cls_end);
  assign emit    = closing && (cls_end >= cls_start)
                && (width >= SEGW_W'(cfg.min_run_width))
                && (4'(runs_r) < limit);

  // Next run state and result
  always_comb begin
    run_open_nxt  = run_open_r;
    run_start_nxt = run_start_r;
    last_col_nxt  = last_col_r;
    gap_nxt       = gap_r;
    runs_nxt      = runs_r;
    result_nxt    = result_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (advance) begin
      out_valid_nxt = 1'b1;
      if (closing) begin
        run_open_nxt  = 1'b0;
        run_start_nxt = '0;
        last_col_nxt  = '0;
        gap_nxt       = '0;
      end else begin
        run_open_nxt  = open_step;
        run_start_nxt = start_step;
        last_col_nxt  = last_step;
        if (is_blue) begin
          gap_nxt = '0;
        end else if (run_open_r) begin
          gap_nxt = gap_r + 4'd1;
        end
      end
      if (item.row_end) begin
        runs_nxt = '0;
      end else if (emit) begin
        runs_nxt = runs_r + RUNS_W'(1);
      end
      result_nxt = '0;
      result_nxt.is_blue = is_blue;
      if (emit) begin
        result_nxt.segment_valid  = 1'b1;
        result_nxt.segment_first  = cls_start;
        result_nxt.segment_end    = cls_end;
        result_nxt.segment_center = col_sum[COL_W:1];
        result_nxt.segment_span   = width;
        result_nxt.segment_row    = item.line;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_open_r  <= 1'b0;
      run_start_r <= '0;
      last_col_r  <= '0;
      gap_r       <= '0;
      runs_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      run_open_r  <= run_open_nxt;
      run_start_r <= run_start_nxt;
      last_col_r  <= last_col_nxt;
      gap_r       <= gap_nxt;
      runs_r      <= runs_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

  // Idle run holds cleared bookkeeping
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !run_open_r |-> (gap_r == '0 && run_start_r == '0 && last_col_r == '0))
    else $error("closed run left stale state");

  // Emitted width matches its span
  a_width: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && result_r.segment_valid) |->
      (result_r.segment_span == SEGW_W'(result_r.segment_end)
                                - SEGW_W'(result_r.segment_first) + SEGW_W'(1)))
    else $error("segment width disagrees with start and end");

  // Non-emitting result carries zero segment fields
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !result_r.segment_valid) |->
      (result_r.segment_first == '0 && result_r.segment_span == '0
       && result_r.segment_row == '0))
    else $error("segment fields set without emission");

  // Row count stays within the cap
  a_runs_cap: assert property (@(posedge clk) disable iff (!rst_n)
    4'(runs_r) <= RUN_CAP)
    else $error("row segment count over cap");

  // An emission bumps the count unless the row ends
  a_runs_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && emit && !item.row_end) |=> (runs_r == $past(runs_r) + RUNS_W'(1)))
    else $error("segment count did not advance");

endmodule

@@ rtl/blue_pixel_run_segmenter.sv @@
// Top level: input register, classifier, run tracker and register file.
`timescale 1ns / 1ps
// A pixel beat waits in the input register until it advances into the result register.
// Throughput: one pixel per cycle unless output stalls; the single run-state update per pixel
//   (classify, gap and close decision) sits between the input and result registers.
// While a result waits unaccepted, an empty input register takes one beat, then input stalls.
// Reset (rst_n low, synchronous): both channels empty, no run open, row count zero,
//   thresholds back to their defaults. No clearing pass.

module blue_pixel_run_segmenter
  import bpr_pkg::*;
#(
  parameter int MAX_RUNS = BPR_MAX_RUNS
) (
  input  logic     clk,
  input  logic     rst_n,
  bpr_pix_if.sink   in_pix,
  bpr_seg_if.source out_seg,
  bpr_cfg_if.sink   cfg_wr
);

  logic  s1_valid_r, s1_valid_nxt;
  pix_t  s1_item_r, s1_item_nxt;
  logic  advance;
  logic  in_take;
  logic  is_blue;
  logic  out_valid;
  cfg_t  cfg;
  seg_t  result;

  // Registers always take a write
  assign cfg_wr.ready = 1'b1;

  bpr_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr.valid),
    .wr_index (cfg_wr.index),
    .wr_data  (cfg_wr.data),
    .cfg      (cfg)
  );

  // Advance when the result slot is free or draining
  assign advance      = s1_valid_r && (!out_valid || out_seg.ready);
  assign in_pix.ready = !s1_valid_r || advance;
  assign in_take      = in_pix.valid && in_pix.ready;

  // Input register
  always_comb begin
    s1_valid_nxt = in_take || (s1_valid_r && !advance);
    s1_item_nxt  = s1_item_r;
    if (in_take) begin
      s1_item_nxt = '{pixel: in_pix.pixel, column: in_pix.column,
                      line: in_pix.line, row_end: in_pix.row_end};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
  end

  bpr_classify u_classify (
    .pixel   (s1_item_r.pixel),
    .cfg     (cfg),
    .is_blue (is_blue)
  );

  bpr_run #(
    .MAX_RUNS (MAX_RUNS)
  ) u_run (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .item      (s1_item_r),
    .is_blue   (is_blue),
    .cfg       (cfg),
    .out_ready (out_seg.ready),
    .out_valid (out_valid),
    .result    (result)
  );

  // Drive the result channel
  assign out_seg.valid          = out_valid;
  assign out_seg.is_blue        = result.is_blue;
  assign out_seg.segment_valid  = result.segment_valid;
  assign out_seg.segment_first  = result.segment_first;
  assign out_seg.segment_end    = result.segment_end;
  assign out_seg.segment_center = result.segment_center;
  assign out_seg.segment_span   = result.segment_span;
  assign out_seg.segment_row    = result.segment_row;

endmodule
